// ===== src/display_frame_responder_top_defines.svh =====
// ---------------------------------------------------------------------------
// display_frame_responder_top_defines
// assertion macros for the checker of the display frame responder
// ---------------------------------------------------------------------------
`ifndef DISPLAY_FRAME_RESPONDER_TOP_DEFINES_SVH
`define DISPLAY_FRAME_RESPONDER_TOP_DEFINES_SVH

// clocked check, muted while reset is high
`define DFR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds across reset
`define DFR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/dfr_pkg.sv =====
// ---------------------------------------------------------------------------
// dfr_pkg
// types, frame constants and the password table of the display frame responder
// ---------------------------------------------------------------------------
`default_nettype none

package dfr_pkg;

  localparam logic [7:0] HDR_HEAD       = 8'h3A;
  localparam logic [7:0] HDR_ADDR       = 8'h1A;
  localparam logic [7:0] CMD_SET        = 8'h53;
  localparam logic [7:0] CMD_RUN        = 8'h52;
  localparam logic [7:0] END_CR         = 8'h0D;
  localparam logic [7:0] END_LF         = 8'h0A;
  localparam logic [7:0] REPLY_DATA_LEN = 8'h05;

  localparam logic [3:0] LEN_SET      = 4'd15;
  localparam logic [3:0] LEN_RUN      = 4'd10;
  localparam logic [3:0] CSUM_AT_SET  = 4'd11;
  localparam logic [3:0] CSUM_AT_RUN  = 4'd6;
  localparam logic [3:0] PROG_AT      = 4'd4;
  localparam logic [3:0] PW_AT        = 4'd9;
  localparam logic [3:0] REPLY_LAST   = 4'd12;

  localparam logic [7:0] PW_ROM [64] = '{
    8'd137, 8'd159, 8'd134, 8'd249, 8'd88,  8'd11,  8'd250, 8'd61,
    8'd33,  8'd150, 8'd3,   8'd193, 8'd118, 8'd141, 8'd209, 8'd94,
    8'd226, 8'd68,  8'd146, 8'd158, 8'd145, 8'd127, 8'd216, 8'd62,
    8'd116, 8'd230, 8'd101, 8'd211, 8'd251, 8'd54,  8'd229, 8'd247,
    8'd20,  8'd222, 8'd59,  8'd63,  8'd35,  8'd252, 8'd142, 8'd238,
    8'd23,  8'd197, 8'd84,  8'd77,  8'd147, 8'd173, 8'd210, 8'd57,
    8'd142, 8'd223, 8'd157, 8'd97,  8'd36,  8'd160, 8'd229, 8'd237,
    8'd75,  8'd80,  8'd37,  8'd113, 8'd154, 8'd88,  8'd23,  8'd120
  };

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [7:0] battery_status;
    logic [7:0] motor_current;
    logic [7:0] period_high;
    logic [7:0] period_low;
    logic [7:0] motor_status;
  } item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
    logic [7:0] display_program;
  } result_t;

endpackage

`default_nettype wire

// ===== src/dfr_fifo.sv =====
// ---------------------------------------------------------------------------
// dfr_fifo
// two-entry queue that decouples the engine from either port
// ---------------------------------------------------------------------------
`default_nettype none

module dfr_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             do_wr;
  logic             do_rd;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 2'd1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/dfr_engine.sv =====
// ---------------------------------------------------------------------------
// dfr_engine
// byte window, frame scan sequencer, reply generation and window compaction
// ---------------------------------------------------------------------------
`default_nettype none

module dfr_engine #(
  parameter int WINDOW_DEPTH = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire dfr_pkg::item_t  in_item,
  output logic                 in_take,
  input  wire logic            out_ready,
  output logic                 out_write,
  output dfr_pkg::result_t     out_result
);

  import dfr_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_CHECK   = 8'b0000_0010,
    S_RD      = 8'b0000_0100,
    S_EVAL    = 8'b0000_1000,
    S_REPLY   = 8'b0001_0000,
    S_MOVE_RD = 8'b0010_0000,
    S_MOVE_WR = 8'b0100_0000,
    S_TRIM    = 8'b1000_0000
  } state_t;

  // window memory
  logic [7:0]    held_bytes [WINDOW_DEPTH];
  logic [7:0]    rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [7:0]    wdata;

  state_t        state;
  state_t        mv_resume;
  logic [CW-1:0] held_count;
  logic [CW-1:0] p;
  logic [CW-1:0] i;
  logic [CW-1:0] k;
  logic [3:0]    ridx;
  logic          is_set;
  logic          ok;
  logic [7:0]    cmd;
  logic [7:0]    got_lo;
  logic [7:0]    prog;
  logic [5:0]    pw_idx;
  logic [15:0]   sum;
  item_t         tel;

  logic [CW-1:0] cs;
  logic [CW-1:0] cs_p1;
  logic [CW-1:0] cs_p2;
  logic [CW-1:0] cs_p3;
  logic [CW-1:0] flen;
  logic [CW-1:0] avail;
  logic [CW:0]   pos_sum;
  logic [CW:0]   src_sum;
  logic [7:0]    b7;
  logic [15:0]   reply_sum;

  assign cs    = is_set ? CW'(CSUM_AT_SET) : CW'(CSUM_AT_RUN);
  assign cs_p1 = cs + CW'(1);
  assign cs_p2 = cs + CW'(2);
  assign cs_p3 = cs + CW'(3);
  assign flen  = is_set ? CW'(LEN_SET) : CW'(LEN_RUN);
  assign avail = held_count - p;

  assign pos_sum = {1'b0, p} + {1'b0, i};
  assign src_sum = pos_sum + {1'b0, k};

  always_comb begin
    raddr = pos_sum[AW-1:0];
    if (state == S_MOVE_RD || state == S_MOVE_WR) begin
      raddr = src_sum[AW-1:0];
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = pos_sum[AW-1:0];
    wdata = rdata;
    if (state == S_IDLE && in_valid) begin
      we    = 1'b1;
      waddr = held_count[AW-1:0];
      wdata = in_item.rx_byte;
    end else if (state == S_MOVE_WR) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      held_bytes[waddr] <= wdata;
    end
    rdata <= held_bytes[raddr];
  end

  // reply bytes
  assign b7 = is_set ? PW_ROM[pw_idx] : tel.period_low;
  assign reply_sum = 16'(HDR_ADDR) + 16'(cmd) + 16'(REPLY_DATA_LEN)
                   + 16'(tel.battery_status) + 16'(tel.motor_current)
                   + 16'(tel.period_high) + 16'(b7);

  assign in_take   = (state == S_IDLE) && in_valid;
  assign out_write = (state == S_REPLY) && out_ready;

  always_comb begin
    out_result.last_byte       = (ridx == REPLY_LAST);
    out_result.display_program = prog;
    unique case (ridx)
      4'd0:    out_result.tx_byte = HDR_HEAD;
      4'd1:    out_result.tx_byte = HDR_ADDR;
      4'd2:    out_result.tx_byte = cmd;
      4'd3:    out_result.tx_byte = REPLY_DATA_LEN;
      4'd4:    out_result.tx_byte = tel.battery_status;
      4'd5:    out_result.tx_byte = tel.motor_current;
      4'd6:    out_result.tx_byte = tel.period_high;
      4'd7:    out_result.tx_byte = b7;
      4'd8:    out_result.tx_byte = tel.motor_status;
      4'd9:    out_result.tx_byte = reply_sum[7:0];
      4'd10:   out_result.tx_byte = reply_sum[15:8];
      4'd11:   out_result.tx_byte = END_CR;
      default: out_result.tx_byte = END_LF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mv_resume  <= S_IDLE;
      held_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            tel        <= in_item;
            held_count <= held_count + CW'(1);
            p          <= '0;
            state      <= S_CHECK;
          end
        end
        S_CHECK: begin
          // need three bytes from the scan position to look at a header
          if ({1'b0, held_count} > ({1'b0, p} + (CW + 1)'(2))) begin
            i     <= '0;
            state <= S_RD;
          end else begin
            state <= S_TRIM;
          end
        end
        S_RD: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          priority if (i == CW'(0)) begin
            if (rdata != HDR_HEAD) begin
              p     <= p + CW'(1);
              state <= S_CHECK;
            end else begin
              i     <= CW'(1);
              state <= S_RD;
            end
          end else if (i == CW'(1)) begin
            if (rdata != HDR_ADDR) begin
              p     <= p + CW'(1);
              state <= S_CHECK;
            end else begin
              sum   <= 16'(rdata);
              i     <= CW'(2);
              state <= S_RD;
            end
          end else if (i == CW'(2)) begin
            cmd    <= rdata;
            ok     <= 1'b1;
            is_set <= (rdata == CMD_SET);
            if (rdata == CMD_SET || rdata == CMD_RUN) begin
              if (avail < ((rdata == CMD_SET) ? CW'(LEN_SET) : CW'(LEN_RUN))) begin
                // frame not complete yet, wait for more bytes
                state <= S_TRIM;
              end else begin
                sum   <= sum + 16'(rdata);
                i     <= CW'(3);
                state <= S_RD;
              end
            end else begin
              k         <= CW'(2);
              i         <= '0;
              mv_resume <= S_CHECK;
              state     <= S_MOVE_RD;
            end
          end else begin
            if (i < cs) begin
              sum <= sum + 16'(rdata);
            end
            if (i == cs) begin
              got_lo <= rdata;
            end
            if (i == cs_p1 && {rdata, got_lo} != sum) begin
              ok <= 1'b0;
            end
            if (i == cs_p2 && rdata != END_CR) begin
              ok <= 1'b0;
            end
            if (i == CW'(PROG_AT)) begin
              prog <= rdata;
            end
            if (i == CW'(PW_AT)) begin
              pw_idx <= rdata[5:0];
            end
            if (i == cs_p3) begin
              if (ok && rdata == END_LF) begin
                ridx  <= '0;
                state <= S_REPLY;
              end else begin
                // drop the header pair and rescan at the same place
                k         <= CW'(2);
                i         <= '0;
                mv_resume <= S_CHECK;
                state     <= S_MOVE_RD;
              end
            end else begin
              i     <= i + CW'(1);
              state <= S_RD;
            end
          end
        end
        S_REPLY: begin
          if (out_ready) begin
            if (ridx == REPLY_LAST) begin
              k         <= flen;
              i         <= '0;
              mv_resume <= S_TRIM;
              state     <= S_MOVE_RD;
            end else begin
              ridx <= ridx + 4'd1;
            end
          end
        end
        S_MOVE_RD: begin
          // slide the tail down over the removed span
          if (i == held_count - p - k) begin
            held_count <= held_count - k;
            state      <= mv_resume;
          end else begin
            state <= S_MOVE_WR;
          end
        end
        S_MOVE_WR: begin
          i     <= i + CW'(1);
          state <= S_MOVE_RD;
        end
        S_TRIM: begin
          if (held_count == CW'(WINDOW_DEPTH)) begin
            p         <= '0;
            k         <= CW'(1);
            i         <= '0;
            mv_resume <= S_IDLE;
            state     <= S_MOVE_RD;
          end else begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/display_frame_responder_top.sv =====
// ---------------------------------------------------------------------------
// display_frame_responder_top
// answers display link frames with 13-byte telemetry replies
// ---------------------------------------------------------------------------
// usage:
//   input queue: drive rx_byte and the five telemetry bytes with push; the
//   transaction is taken when push is high and full is low. two items can
//   wait in front of the engine.
//   result queue: while empty is low the oldest reply byte is on tx_byte,
//   last_byte and display_program; pop takes it. a valid frame yields 13
//   result transactions, last_byte marks the thirteenth.
//   pace: an item is loaded in S_IDLE; each scan position runs a bound test
//   in S_CHECK, then S_RD and S_EVAL for each window byte read; each byte
//   slid when bytes are dropped passes S_MOVE_RD and S_MOVE_WR, and a last
//   S_MOVE_RD closes the slide; S_TRIM tests for a full window, and the reply
//   goes out byte by byte while the result queue has room. no new item is
//   taken until the engine is back in S_IDLE.
//   at reset the window is emptied and both queues are cleared.
//   a stalled receiver holds the engine in the reply; the input queue keeps
//   taking items until it fills, then full stays high.
// ---------------------------------------------------------------------------
`default_nettype none

module display_frame_responder_top #(
  parameter int WINDOW_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] battery_status,
  input  wire logic [7:0] motor_current,
  input  wire logic [7:0] period_high,
  input  wire logic [7:0] period_low,
  input  wire logic [7:0] motor_status,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      tx_byte,
  output logic            last_byte,
  output logic [7:0]      display_program
);

  import dfr_pkg::*;

  item_t   push_item;
  item_t   head_item;
  logic    in_empty;
  logic    in_take;
  logic    out_full;
  logic    out_write;
  result_t eng_result;
  result_t head_result;

  assign push_item.rx_byte         = rx_byte;
  assign push_item.battery_status  = battery_status;
  assign push_item.motor_current   = motor_current;
  assign push_item.period_high     = period_high;
  assign push_item.period_low      = period_low;
  assign push_item.motor_status    = motor_status;

  dfr_fifo #(
    .WIDTH ($bits(item_t))
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (push_item),
    .full    (full),
    .rd_en   (in_take),
    .rd_data (head_item),
    .empty   (in_empty)
  );

  dfr_engine #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (!in_empty),
    .in_item    (head_item),
    .in_take    (in_take),
    .out_ready  (!out_full),
    .out_write  (out_write),
    .out_result (eng_result)
  );

  dfr_fifo #(
    .WIDTH ($bits(result_t))
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_write),
    .wr_data (eng_result),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (head_result),
    .empty   (empty)
  );

  assign tx_byte         = head_result.tx_byte;
  assign last_byte       = head_result.last_byte;
  assign display_program = head_result.display_program;

endmodule

`default_nettype wire

// ===== src/dfr_checker.sv =====
// ---------------------------------------------------------------------------
// dfr_checker
// port-level checks on the reply stream of the display frame responder
// ---------------------------------------------------------------------------
`default_nettype none

`include "display_frame_responder_top_defines.svh"

module dfr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] tx_byte,
  input wire logic       last_byte,
  input wire logic [7:0] display_program
);

  import dfr_pkg::*;

  `DFR_ASSERT_ALWAYS(a_reset_empty, rst |=> empty, "result queue not empty after reset")
  `DFR_ASSERT(a_prog_steady, (pop && !empty && !last_byte) |=> (empty || $stable(display_program)), "program changed inside a reply")
  `DFR_ASSERT(a_reply_start, (pop && !empty && last_byte) |=> (empty || tx_byte == HDR_HEAD), "reply does not open with header")
  `DFR_ASSERT(a_stall_hold, (!empty && !pop) |=> !empty, "waiting result vanished")

endmodule

bind display_frame_responder_top dfr_checker u_dfr_checker (
  .clk             (clk),
  .rst             (rst),
  .empty           (empty),
  .pop             (pop),
  .tx_byte         (tx_byte),
  .last_byte       (last_byte),
  .display_program (display_program)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// checks the display frame responder against a byte-level model of its
// frame search; valid, corrupted, truncated and stray frames are pushed
// with random telemetry, and every reply byte popped is compared in order
// ---------------------------------------------------------------------------
module tb_top;
  import dfr_pkg::*;

  localparam int WINDOW_DEPTH = 16;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int FRAME_BYTES  = 480;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;

  localparam logic [7:0] PASSWORD_TABLE [64] = '{
    8'd137, 8'd159, 8'd134, 8'd249, 8'd88,  8'd11,  8'd250, 8'd61,
    8'd33,  8'd150, 8'd3,   8'd193, 8'd118, 8'd141, 8'd209, 8'd94,
    8'd226, 8'd68,  8'd146, 8'd158, 8'd145, 8'd127, 8'd216, 8'd62,
    8'd116, 8'd230, 8'd101, 8'd211, 8'd251, 8'd54,  8'd229, 8'd247,
    8'd20,  8'd222, 8'd59,  8'd63,  8'd35,  8'd252, 8'd142, 8'd238,
    8'd23,  8'd197, 8'd84,  8'd77,  8'd147, 8'd173, 8'd210, 8'd57,
    8'd142, 8'd223, 8'd157, 8'd97,  8'd36,  8'd160, 8'd229, 8'd237,
    8'd75,  8'd80,  8'd37,  8'd113, 8'd154, 8'd88,  8'd23,  8'd120
  };

  typedef enum int {FRAME_OK, FRAME_BAD_SUM, FRAME_BAD_END, FRAME_CUT} frame_fault_t;

  class reply_scoreboard;
    logic [7:0] rx_window[$];
    result_t    pending_tx[$];
    int         errors = 0;

    function void drop(int at, int k);
      repeat (k) rx_window.delete(at);
    endfunction

    // appends one received byte and predicts the reply it triggers, if any
    function void note_rx_byte(item_t it);
      logic [7:0]  cmd;
      logic [7:0]  pw_or_period;
      logic [15:0] frame_sum;
      logic [15:0] frame_csum;
      logic [15:0] reply_sum;
      logic [7:0]  reply [13];
      result_t     r;
      int          p;
      int          len;
      int          cs;
      int          i;
      if (rx_window.size() >= WINDOW_DEPTH) void'(rx_window.pop_front());
      rx_window.push_back(it.rx_byte);
      p = 0;
      while (rx_window.size() > p + 2) begin
        if (rx_window[p] != HDR_HEAD || rx_window[p+1] != HDR_ADDR) begin
          p++;
          continue;
        end
        cmd = rx_window[p+2];
        if (cmd == CMD_SET) begin
          len = LEN_SET;
          cs  = CSUM_AT_SET;
        end else if (cmd == CMD_RUN) begin
          len = LEN_RUN;
          cs  = CSUM_AT_RUN;
        end else begin
          drop(p, 2);
          continue;
        end
        // frame still arriving
        if (rx_window.size() - p < len) break;
        frame_sum = '0;
        for (i = 1; i < cs; i++) frame_sum += rx_window[p+i];
        frame_csum = {rx_window[p+cs+1], rx_window[p+cs]};
        if (rx_window[p+cs+2] != END_CR || rx_window[p+cs+3] != END_LF ||
            frame_csum != frame_sum) begin
          drop(p, 2);
          continue;
        end
        // password index keeps only its low 6 bits
        pw_or_period = (cmd == CMD_SET) ? PASSWORD_TABLE[rx_window[p+PW_AT][5:0]]
                                        : it.period_low;
        reply = '{HDR_HEAD, HDR_ADDR, cmd, REPLY_DATA_LEN, it.battery_status,
                  it.motor_current, it.period_high, pw_or_period, it.motor_status,
                  8'h00, 8'h00, END_CR, END_LF};
        reply_sum = '0;
        for (i = 1; i <= 7; i++) reply_sum += reply[i];
        reply[9]  = reply_sum[7:0];
        reply[10] = reply_sum[15:8];
        for (i = 0; i < 13; i++) begin
          r.tx_byte         = reply[i];
          r.last_byte       = (i == REPLY_LAST);
          r.display_program = rx_window[p+PROG_AT];
          pending_tx.push_back(r);
        end
        drop(p, len);
        break;
      end
      if (rx_window.size() >= WINDOW_DEPTH) void'(rx_window.pop_front());
    endfunction

    function void check_tx_byte(result_t got);
      result_t want;
      if (pending_tx.size() == 0) begin
        errors++;
        $display("%0t: reply byte %h popped with nothing expected", $time, got.tx_byte);
        return;
      end
      want = pending_tx.pop_front();
      if (got.tx_byte !== want.tx_byte) begin
        errors++;
        $display("%0t: tx_byte expected %h, got %h", $time, want.tx_byte, got.tx_byte);
      end
      if (got.last_byte !== want.last_byte) begin
        errors++;
        $display("%0t: last_byte expected %b, got %b", $time, want.last_byte,
                 got.last_byte);
      end
      if (got.display_program !== want.display_program) begin
        errors++;
        $display("%0t: display_program expected %h, got %h", $time,
                 want.display_program, got.display_program);
      end
    endfunction

    function int pending();
      return pending_tx.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       pop = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic [7:0] battery_status = 8'h00;
  logic [7:0] motor_current = 8'h00;
  logic [7:0] period_high = 8'h00;
  logic [7:0] period_low = 8'h00;
  logic [7:0] motor_status = 8'h00;
  logic       full;
  logic       empty;
  logic [7:0] tx_byte;
  logic       last_byte;
  logic [7:0] display_program;

  reply_scoreboard sb = new();
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          frame_bytes = 0;
  bit          hold_req = 1'b0;
  int unsigned cycle_count;

  display_frame_responder_top #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .rx_byte         (rx_byte),
    .battery_status  (battery_status),
    .motor_current   (motor_current),
    .period_high     (period_high),
    .period_low      (period_low),
    .motor_status    (motor_status),
    .empty           (empty),
    .pop             (pop),
    .tx_byte         (tx_byte),
    .last_byte       (last_byte),
    .display_program (display_program)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] telemetry_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // tel < 0 picks random telemetry, otherwise every telemetry field gets tel
  task automatic send_byte(input logic [7:0] value, input int tel);
    item_t it;
    it.rx_byte         = value;
    it.battery_status  = (tel < 0) ? telemetry_byte() : 8'(tel);
    it.motor_current   = (tel < 0) ? telemetry_byte() : 8'(tel);
    it.period_high     = (tel < 0) ? telemetry_byte() : 8'(tel);
    it.period_low      = (tel < 0) ? telemetry_byte() : 8'(tel);
    it.motor_status    = (tel < 0) ? telemetry_byte() : 8'(tel);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push            <= 1'b1;
    rx_byte         <= it.rx_byte;
    battery_status  <= it.battery_status;
    motor_current   <= it.motor_current;
    period_high     <= it.period_high;
    period_low      <= it.period_low;
    motor_status    <= it.motor_status;
    do @(posedge clk); while (full);
    sb.note_rx_byte(it);
  endtask

  // body < 0 fills the payload with random bytes
  task automatic send_frame(input logic [7:0] cmd, input frame_fault_t fault,
                            input int body, input int tel);
    logic [7:0]  fr[$];
    logic [15:0] csum;
    int          cs;
    int          len;
    int          i;
    cs  = (cmd == CMD_SET) ? CSUM_AT_SET : CSUM_AT_RUN;
    len = (cmd == CMD_SET) ? LEN_SET : LEN_RUN;
    fr  = {HDR_HEAD, HDR_ADDR, cmd};
    for (i = 3; i < cs; i++) fr.push_back((body < 0) ? 8'($urandom) : 8'(body));
    csum = '0;
    for (i = 1; i < cs; i++) csum += fr[i];
    fr.push_back(csum[7:0]);
    fr.push_back(csum[15:8]);
    fr.push_back(END_CR);
    fr.push_back(END_LF);
    case (fault)
      FRAME_BAD_SUM: fr[cs + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
      FRAME_BAD_END: fr[cs + 2 + $urandom_range(1)] ^= 8'($urandom_range(1, 255));
      FRAME_CUT: begin
        i = $urandom_range(3, len - 1);
        while (fr.size() > i) void'(fr.pop_back());
      end
      default: ;
    endcase
    foreach (fr[j]) send_byte(fr[j], tel);
    frame_bytes += fr.size();
  endtask

  task automatic send_unknown_header(input int tel);
    logic [7:0] cmd;
    do cmd = 8'($urandom); while (cmd == CMD_SET || cmd == CMD_RUN);
    send_byte(HDR_HEAD, tel);
    send_byte(HDR_ADDR, tel);
    send_byte(cmd, tel);
    frame_bytes += 3;
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: errors");
    $finish;
  end

  // result side: pop at random, with one long hold-off to back the block up
  initial begin
    int      hold_left;
    result_t got;
    hold_left = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        got.tx_byte         = tx_byte;
        got.last_byte       = last_byte;
        got.display_program = display_program;
        sb.check_tx_byte(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int pick;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // all-zero running payload with full-scale telemetry, a header with an
    // unknown command, then a settings frame whose password byte needs masking
    send_frame(CMD_RUN, FRAME_OK, 8'h00, 8'hFF);
    send_unknown_header(8'h00);
    send_frame(CMD_SET, FRAME_OK, 8'hFF, 8'h00);

    frame_bytes = 0;
    hold_req    = 1'b1;
    while (frame_bytes < FRAME_BYTES) begin
      case (frame_bytes * 4 / FRAME_BYTES)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
      endcase
      pick = $urandom_range(99);
      if (pick < 35)
        send_frame(CMD_RUN, FRAME_OK, -1, -1);
      else if (pick < 65)
        send_frame(CMD_SET, FRAME_OK, -1, -1);
      else if (pick < 75)
        send_frame($urandom_range(1) ? CMD_SET : CMD_RUN, FRAME_BAD_SUM, -1, -1);
      else if (pick < 83)
        send_frame($urandom_range(1) ? CMD_SET : CMD_RUN, FRAME_BAD_END, -1, -1);
      else if (pick < 88)
        send_frame($urandom_range(1) ? CMD_SET : CMD_RUN, FRAME_CUT, -1, -1);
      else if (pick < 92)
        send_unknown_header(-1);
      else begin
        // line noise, long enough at times to fill the window
        pick = $urandom_range(1, 20);
        repeat (pick)
          send_byte(($urandom_range(7) == 0) ? HDR_HEAD : 8'($urandom), -1);
        frame_bytes += pick;
      end
    end
    push <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/dfr_pkg.sv
src/dfr_fifo.sv
src/dfr_engine.sv
src/display_frame_responder_top.sv
src/dfr_checker.sv
sim/tb_top.sv
